// File: design/bounded_int_deque_unit_defines.svh
// assertion macros shared by the deque unit
`ifndef BOUNDED_INT_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_INT_DEQUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque unit check failed");

// next-cycle implication, checked outside reset
`define BID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque unit check failed");

`endif

// File: design/bid_pkg.sv
package bid_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    // slave tdata: value, position
    localparam int IN_TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_HEAD = 3'd0,
        MODE_PUSH_TAIL = 3'd1,
        MODE_POP_HEAD  = 3'd2,
        MODE_POP_TAIL  = 3'd3,
        MODE_READ_AT   = 3'd4,
        MODE_READ_HEAD = 3'd5,
        MODE_READ_TAIL = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// File: design/bid_ram.sv
module bid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bounded_int_deque_unit.sv
// bounded deque of signed 32-bit values held in a ring buffer of DEPTH entries
// request channel s_*: s_tuser carries the mode, s_tdata the value and position;
// a transaction is taken when s_tvalid and s_tready are both high
// response channel m_*: one transaction per request, in request order, giving the
// data read or popped, the status, the empty flag and the count after the request
// m_tvalid is registered: the ram read register and the pending stage load at the
// accepting edge, the output register when the pending stage moves on
// throughput: one request per cycle while responses are taken; head index and count
// are updated at accept time, so the next request already sees the new pointers, and
// each request makes at most one access to the single-port-per-direction ram
// when the receiver stalls the response waits in the output register, one more
// request can finish its ram access behind it, and then s_tready drops
// reset empties the deque (head index and count to zero) and drops m_tvalid;
// the ram contents are not cleared, only slots inside the occupied window are read
module bounded_int_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value [31:0], position [39:32]
    input  logic [bid_pkg::IN_TDATA_W-1:0]  s_tdata,
    // mode [2:0]
    input  logic [bid_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data [31:0], empty_res [32], count [32+CNT_W:33], zero fill to whole bytes
    output logic [((bid_pkg::VALUE_W + 1 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // status [1:0]
    output logic [bid_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int AW      = $clog2(DEPTH);
    localparam int AW1     = AW + 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = bid_pkg::POS_W + 1;
    localparam int VW      = bid_pkg::VALUE_W;

    // pointer state
    logic [AW-1:0]    head_reg, head_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    // request fields
    bid_pkg::mode_t            mode;
    logic [VW-1:0]             value;
    logic [bid_pkg::POS_W-1:0] position;

    logic              acc;
    logic              full, empty;
    logic [CNT_W-1:0]  occ_m1;
    logic [AW-1:0]     head_dec, head_inc;
    logic              pos_ok;
    logic              wr_en, rd_en;
    logic [AW-1:0]     addr;
    bid_pkg::status_t  status;
    logic [VW-1:0]     ram_rdata;

    // ram access stage
    logic              p_valid_reg, p_valid_next;
    logic              p_rd_reg;
    bid_pkg::status_t  p_status_reg;
    logic [CNT_W-1:0]  p_count_reg;
    logic              p_move;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [VW-1:0]     out_data_reg;
    bid_pkg::status_t  out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] k);
        logic [AW1-1:0] sum;
        sum = {1'b0, base} + {1'b0, k};
        if (sum >= AW1'(DEPTH))
        begin
            sum = sum - AW1'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign mode     = bid_pkg::mode_t'(s_tuser);
    assign value    = s_tdata[VW-1:0];
    assign position = s_tdata[VW +: bid_pkg::POS_W];

    assign p_move   = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || p_move;
    assign acc      = s_tvalid && s_tready;

    assign full     = (occ_reg == CNT_W'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign occ_m1   = occ_reg - CNT_W'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign pos_ok   = ({1'b0, position} < CMP_W'(occ_reg));

    // request decode: pointer update and the single ram access
    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        addr      = head_reg;
        status    = bid_pkg::ST_OK;
        unique case (mode)
            bid_pkg::MODE_PUSH_HEAD:
            begin
                if (full)
                begin
                    status = bid_pkg::ST_FULL;
                end
                else
                begin
                    addr      = head_dec;
                    wr_en     = acc;
                    head_next = head_dec;
                    occ_next  = occ_reg + CNT_W'(1);
                end
            end
            bid_pkg::MODE_PUSH_TAIL:
            begin
                if (full)
                begin
                    status = bid_pkg::ST_FULL;
                end
                else
                begin
                    addr     = slot_of(head_reg, occ_reg[AW-1:0]);
                    wr_en    = acc;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            bid_pkg::MODE_POP_HEAD:
            begin
                if (empty)
                begin
                    status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    addr      = head_reg;
                    rd_en     = acc;
                    head_next = head_inc;
                    occ_next  = occ_m1;
                end
            end
            bid_pkg::MODE_POP_TAIL:
            begin
                if (empty)
                begin
                    status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    addr     = slot_of(head_reg, occ_m1[AW-1:0]);
                    rd_en    = acc;
                    occ_next = occ_m1;
                end
            end
            bid_pkg::MODE_READ_AT:
            begin
                if (!pos_ok)
                begin
                    status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    addr  = slot_of(head_reg, position[AW-1:0]);
                    rd_en = acc;
                end
            end
            bid_pkg::MODE_READ_HEAD:
            begin
                if (empty)
                begin
                    status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    addr  = head_reg;
                    rd_en = acc;
                end
            end
            bid_pkg::MODE_READ_TAIL:
            begin
                if (empty)
                begin
                    status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    addr  = slot_of(head_reg, occ_m1[AW-1:0]);
                    rd_en = acc;
                end
            end
            default:
            begin
                status = bid_pkg::ST_OK;
            end
        endcase
    end

    bid_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (acc)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_move)
        begin
            p_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (p_move)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            occ_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                head_reg <= head_next;
                occ_reg  <= occ_next;
            end
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_rd_reg     <= rd_en;
            p_status_reg <= status;
            p_count_reg  <= occ_next;
        end
        if (p_move)
        begin
            out_data_reg   <= p_rd_reg ? ram_rdata : '0;
            out_status_reg <= p_status_reg;
            out_count_reg  <= p_count_reg;
        end
    end

    always_comb
    begin
        m_tdata                  = '0;
        m_tdata[VW-1:0]          = out_data_reg;
        m_tdata[VW]              = (out_count_reg == '0);
        m_tdata[VW + 1 +: CNT_W] = out_count_reg;
    end

    assign m_tuser  = out_status_reg;
    assign m_tvalid = m_valid_reg;

`include "bounded_int_deque_unit_defines.svh"

    `BID_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= CNT_W'(DEPTH))
    `BID_ASSERT_NOW(a_ram_one_port, 1'b1, !(wr_en && rd_en))
    `BID_ASSERT_NEXT(a_acc_pending, acc, p_valid_reg)
    `BID_ASSERT_NOW(a_full_count, m_valid_reg && (out_status_reg == bid_pkg::ST_FULL), out_count_reg == CNT_W'(DEPTH))
    `BID_ASSERT_NOW(a_no_write_on_reject, acc && (status != bid_pkg::ST_OK), !wr_en && !rd_en && (occ_next == occ_reg))

endmodule
